/* rtl/core/held_note_tracker_top_defines.svh */
// assertion macros for the held note tracker
// used by held_note_tracker_top, expects clk and arst_n in scope
`ifndef HELD_NOTE_TRACKER_TOP_DEFINES_SVH
`define HELD_NOTE_TRACKER_TOP_DEFINES_SVH

// property holds on every clock edge outside reset
`define HNT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger in one cycle implies outcome in the next
`define HNT_ASSERT_NEXT(label, trig, outcome, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (outcome)) \
		else $error(msg);

`endif

/* rtl/core/hnt_pkg.sv */
// shared types and constants of the held note tracker
// no dependencies
package hnt_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int MAX_RESULTS = 32;
	localparam logic [6:0] VELOCITY_AT_RESET = 7'd100;

	localparam logic [1:0] OP_TRANSPORT = 2'd0;
	localparam logic [1:0] OP_NOTE_OFF = 2'd1;
	localparam logic [1:0] OP_NOTE_ON = 2'd2;

	localparam logic [1:0] RS_STOPPED = 2'd0;
	localparam logic [1:0] RS_FIRST_TICK = 2'd1;
	localparam logic [1:0] RS_RUNNING = 2'd2;
	localparam logic [1:0] RS_RESET = 2'd3;

	typedef struct packed {
		logic [3:0] channel;
		logic [6:0] key;
	} entry_t;

	typedef struct packed {
		logic rotate;
		logic purge;
		logic append;
		entry_t new_entry;
		entry_t match;
	} cell_ctrl_t;

endpackage

/* rtl/core/hnt_cell.sv */
// one slot of the held note chain: holds an entry, shifts from its right neighbor
// depends on hnt_pkg
module hnt_cell #(
	parameter int COUNT_W = 6,
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  hnt_pkg::cell_ctrl_t ctrl,
	input  logic [COUNT_W-1:0] count,
	input  hnt_pkg::entry_t    right,
	input  logic               shift_in,
	output logic               shift_out,
	output hnt_pkg::entry_t    entry
);
	import hnt_pkg::*;

	entry_t entry_q;
	logic   occupied;
	logic   hit;

	assign occupied  = COUNT_W'(INDEX) < count;
	assign hit       = ctrl.purge && occupied && (entry_q == ctrl.match);
	assign shift_out = shift_in || hit;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.rotate || (ctrl.purge && shift_out)) begin
			entry_q <= right;
		end else if (ctrl.append && (count == COUNT_W'(INDEX))) begin
			entry_q <= ctrl.new_entry;
		end
	end

endmodule

/* rtl/core/held_note_tracker_top.sv */
// note event: while running, its result is in the output register the cycle after acceptance
// note-off purge: the chain shifts out one match a cycle until no held entry matches
// transport flush: the chain rotates once fully, one result per cycle for at most MAX_RESULTS
// held entries, first via state then output register; stalls hold rotation while emitting
// arst_n clears held count, run flag, output valid; restart velocity to 100; table undefined
`include "held_note_tracker_top_defines.svh"

module held_note_tracker_top #(
	parameter int TABLE_DEPTH = hnt_pkg::TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [1:0] run_state,
	input  logic [3:0] channel,
	input  logic [6:0] key,
	input  logic [6:0] velocity,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_note_on,
	output logic [3:0] out_channel,
	output logic [6:0] out_key,
	output logic [6:0] out_velocity,
	output logic       dropped,
	output logic       last
);
	import hnt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int MAX_LEN = (TABLE_DEPTH < MAX_RESULTS) ? TABLE_DEPTH : MAX_RESULTS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_PURGE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] step_q;
	logic [CNT_W-1:0] flush_len_q;
	logic             was_running_q;
	logic [6:0]       restart_vel_q;
	logic             flush_on_q;
	logic [6:0]       flush_vel_q;
	entry_t           match_q;
	logic             out_valid_q;
	logic             out_on_q;
	entry_t           out_entry_q;
	logic [6:0]       out_vel_q;
	logic             out_drop_q;
	logic             out_last_q;

	cell_ctrl_t       ctrl;
	entry_t           cell_entry [TABLE_DEPTH];
	logic [TABLE_DEPTH:0] shift_chain;
	logic             any_hit;
	logic             out_free;
	logic             accept;
	logic             running_in;
	logic             emitting;
	logic             full;
	logic [CNT_W-1:0] flush_len;
	entry_t           in_entry;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE) || !out_free;
	assign accept     = in_valid && !in_stall;
	assign running_in = (run_state == RS_FIRST_TICK) || (run_state == RS_RUNNING);
	assign emitting   = step_q < flush_len_q;
	assign full       = count_q == CNT_W'(TABLE_DEPTH);
	assign flush_len  = (count_q > CNT_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : count_q;
	assign in_entry   = '{channel: channel, key: key};

	always_comb begin
		ctrl           = '0;
		ctrl.rotate    = (state_q == ST_FLUSH) && (!emitting || out_free);
		ctrl.purge     = state_q == ST_PURGE;
		ctrl.append    = accept && (operation == OP_NOTE_ON) && was_running_q && !full;
		ctrl.new_entry = in_entry;
		ctrl.match     = match_q;
	end

	assign shift_chain[0] = 1'b0;
	assign any_hit        = shift_chain[TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		hnt_cell #(
			.COUNT_W (CNT_W),
			.INDEX   (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.right     (cell_entry[(i + 1) % TABLE_DEPTH]),
			.shift_in  (shift_chain[i]),
			.shift_out (shift_chain[i+1]),
			.entry     (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			step_q        <= '0;
			flush_len_q   <= '0;
			was_running_q <= 1'b0;
			restart_vel_q <= VELOCITY_AT_RESET;
			flush_on_q    <= 1'b0;
			flush_vel_q   <= '0;
			match_q       <= '0;
			out_valid_q   <= 1'b0;
			out_on_q      <= 1'b0;
			out_entry_q   <= '0;
			out_vel_q     <= '0;
			out_drop_q    <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				restart_vel_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_TRANSPORT: begin
								was_running_q <= running_in;
								flush_len_q   <= flush_len;
								step_q        <= '0;
								if (!running_in) begin
									flush_on_q  <= 1'b0;
									flush_vel_q <= '0;
									if (was_running_q && (count_q != '0)) begin
										state_q <= ST_FLUSH;
									end
									if (run_state == RS_RESET) begin
										count_q <= '0;
									end
								end else if (!was_running_q && (count_q != '0)) begin
									flush_on_q  <= 1'b1;
									flush_vel_q <= restart_vel_q;
									state_q     <= ST_FLUSH;
								end
							end
							OP_NOTE_OFF: begin
								if (was_running_q) begin
									out_valid_q <= 1'b1;
									out_on_q    <= 1'b0;
									out_entry_q <= in_entry;
									out_vel_q   <= '0;
									out_drop_q  <= 1'b0;
									out_last_q  <= 1'b1;
									match_q     <= in_entry;
									state_q     <= ST_PURGE;
								end
							end
							OP_NOTE_ON: begin
								if (was_running_q) begin
									out_valid_q <= 1'b1;
									out_on_q    <= 1'b1;
									out_entry_q <= in_entry;
									out_vel_q   <= velocity;
									out_drop_q  <= full;
									out_last_q  <= 1'b1;
									if (!full) begin
										count_q <= count_q + CNT_W'(1);
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_FLUSH: begin
					if (ctrl.rotate) begin
						step_q <= step_q + CNT_W'(1);
						if (emitting) begin
							out_valid_q <= 1'b1;
							out_on_q    <= flush_on_q;
							out_entry_q <= cell_entry[0];
							out_vel_q   <= flush_vel_q;
							out_drop_q  <= 1'b0;
							out_last_q  <= (step_q + CNT_W'(1)) == flush_len_q;
						end
						if (step_q == CNT_W'(TABLE_DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PURGE: begin
					if (any_hit) begin
						count_q <= count_q - CNT_W'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign is_note_on   = out_on_q;
	assign out_channel  = out_entry_q.channel;
	assign out_key      = out_entry_q.key;
	assign out_velocity = out_vel_q;
	assign dropped      = out_drop_q;
	assign last         = out_last_q;

	`HNT_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "held count beyond table depth")
	`HNT_ASSERT_NEXT(a_append_count, ctrl.append, count_q == $past(count_q) + CNT_W'(1), "append did not grow the count")
	`HNT_ASSERT_NEXT(a_purge_done, (state_q == ST_PURGE) && !any_hit, state_q == ST_IDLE, "purge did not end without a match")

endmodule

/* dv/held_note_tracker_checker.sv */
// checker for held_note_tracker_top: follows both channels and the velocity register,
// keeps its own copy of the held note table and compares every output transfer
// depends on hnt_pkg
module held_note_tracker_checker #(
	parameter int TABLE_DEPTH = hnt_pkg::TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] operation,
	input  logic [1:0] run_state,
	input  logic [3:0] channel,
	input  logic [6:0] key,
	input  logic [6:0] velocity,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       is_note_on,
	input  logic [3:0] out_channel,
	input  logic [6:0] out_key,
	input  logic [6:0] out_velocity,
	input  logic       dropped,
	input  logic       last,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import hnt_pkg::*;

	typedef struct packed {
		logic       note_on;
		logic [3:0] channel;
		logic [6:0] key;
		logic [6:0] velocity;
		logic       dropped;
		logic       last;
	} midi_msg_t;

	entry_t      held_tab [TABLE_DEPTH];
	int unsigned held_len;
	logic        transport_on;
	logic [6:0]  restart_vel;
	midi_msg_t   expected_msgs [$];
	int          errors = 0;

	task automatic compare_field(input string label, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
		end
	endtask

	task automatic queue_msg(input midi_msg_t msg);
		expected_msgs.insert(expected_msgs.size(), msg);
	endtask

	task automatic predict_transfer(input logic [1:0] op, input logic [1:0] rs,
			input entry_t note, input logic [6:0] vel);
		midi_msg_t   m;
		logic        now_on;
		int unsigned n_out;
		int unsigned w;
		m = '0;
		case (op)
			OP_TRANSPORT: begin
				now_on = (rs == RS_FIRST_TICK) || (rs == RS_RUNNING);
				if (now_on != transport_on) begin
					n_out = (held_len < MAX_RESULTS) ? held_len : MAX_RESULTS;
					for (int i = 0; i < n_out; i++) begin
						m.note_on = now_on;
						m.channel = held_tab[i].channel;
						m.key = held_tab[i].key;
						m.velocity = now_on ? restart_vel : 7'd0;
						m.dropped = 1'b0;
						m.last = (i == n_out - 1);
						queue_msg(m);
					end
				end
				if (rs == RS_RESET)
					held_len = 0;
				transport_on = now_on;
			end
			OP_NOTE_OFF: begin
				if (transport_on) begin
					m.note_on = 1'b0;
					m.channel = note.channel;
					m.key = note.key;
					m.velocity = 7'd0;
					m.last = 1'b1;
					queue_msg(m);
					w = 0;
					for (int r = 0; r < held_len; r++) begin
						if (held_tab[r] != note) begin
							held_tab[w] = held_tab[r];
							w++;
						end
					end
					held_len = w;
				end
			end
			OP_NOTE_ON: begin
				if (transport_on) begin
					m.note_on = 1'b1;
					m.channel = note.channel;
					m.key = note.key;
					m.velocity = vel;
					m.dropped = (held_len >= TABLE_DEPTH);
					m.last = 1'b1;
					if (!m.dropped) begin
						held_tab[held_len] = note;
						held_len++;
					end
					queue_msg(m);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		midi_msg_t want;
		if (!arst_n) begin
			held_len = 0;
			transport_on = 1'b0;
			restart_vel = VELOCITY_AT_RESET;
			expected_msgs.delete();
		end else begin
			if (cfg_wr_en)
				restart_vel = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_msgs.size() == 0) begin
					errors++;
					$display("%0t ns: output transfer, expected none, actual ch %0d key %0d",
						$time, out_channel, out_key);
				end else begin
					want = expected_msgs.pop_front();
					compare_field("is_note_on", want.note_on, is_note_on);
					compare_field("out_channel", want.channel, out_channel);
					compare_field("out_key", want.key, out_key);
					compare_field("out_velocity", want.velocity, out_velocity);
					compare_field("dropped", want.dropped, dropped);
					compare_field("last", want.last, last);
				end
			end
			if (in_valid && !in_stall)
				predict_transfer(operation, run_state, {channel, key}, velocity);
		end
		fail_count <= errors;
		pending <= expected_msgs.size();
	end

endmodule

/* dv/tb.sv */
// top of the held note tracker testbench: clock, reset, stimulus and verdict
// depends on hnt_pkg, held_note_tracker_top and held_note_tracker_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hnt_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int SETTLE = 2 * DEPTH + 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] operation = '0;
	logic [1:0] run_state = '0;
	logic [3:0] channel = '0;
	logic [6:0] key = '0;
	logic [6:0] velocity = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       is_note_on;
	logic [3:0] out_channel;
	logic [6:0] out_key;
	logic [6:0] out_velocity;
	logic       dropped;
	logic       last;
	int         fail_count;
	int         pending;

	int unsigned n_sent = 0;
	int unsigned burst_left = 0;
	entry_t      note_pool [6];

	held_note_tracker_top #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

	held_note_tracker_checker #(.TABLE_DEPTH(DEPTH)) u_checker (.*);

	always #6 clk = ~clk;

	task automatic offer(input logic [1:0] op, input logic [1:0] rs, input logic [3:0] ch,
			input logic [6:0] k, input logic [6:0] vel);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		operation <= op;
		run_state <= rs;
		channel <= ch;
		key <= k;
		velocity <= vel;
		do @(posedge clk); while (in_stall);
		burst_left--;
		n_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_restart_velocity(input logic [6:0] vel);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= vel;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic refresh_pool();
		for (int i = 0; i < 6; i++)
			note_pool[i] = 11'($urandom);
	endtask

	task automatic random_note_events(input int unsigned want);
		int unsigned done;
		int unsigned pick;
		entry_t      e;
		logic [1:0]  op;
		logic [1:0]  rs;
		done = 0;
		while (done < want) begin
			pick = $urandom_range(0, 99);
			rs = 2'($urandom);
			if ($urandom_range(0, 3) != 0)
				e = note_pool[$urandom_range(0, 5)];
			else
				e = 11'($urandom);
			if (pick < 8) begin
				op = OP_TRANSPORT;
				rs = $urandom_range(0, 1) ? RS_RUNNING : RS_FIRST_TICK;
			end else if (pick < 14) begin
				op = OP_TRANSPORT;
				rs = (pick < 12) ? RS_STOPPED : RS_RESET;
			end else if (pick < 18) begin
				op = OP_UNUSED;
			end else if (pick < 62) begin
				op = OP_NOTE_ON;
			end else begin
				op = OP_NOTE_OFF;
			end
			done++;
			offer(op, rs, e.channel, e.key, 7'($urandom));
		end
	endtask

	// overflow the table, then flush it both ways and clear it
	task automatic fill_table();
		entry_t e;
		entry_t first_e;
		offer(OP_TRANSPORT, RS_RUNNING, 4'($urandom), 7'($urandom), 7'($urandom));
		first_e = 11'($urandom);
		offer(OP_NOTE_ON, 2'($urandom), first_e.channel, first_e.key, 7'($urandom));
		for (int i = 0; i < DEPTH + 2; i++) begin
			e = 11'($urandom);
			offer(OP_NOTE_ON, 2'($urandom), e.channel, e.key, 7'($urandom));
		end
		offer(OP_TRANSPORT, RS_STOPPED, 4'($urandom), 7'($urandom), 7'($urandom));
		offer(OP_TRANSPORT, RS_FIRST_TICK, 4'($urandom), 7'($urandom), 7'($urandom));
		offer(OP_NOTE_OFF, 2'($urandom), first_e.channel, first_e.key, 7'($urandom));
		offer(OP_NOTE_ON, 2'($urandom), first_e.channel, first_e.key, 7'($urandom));
		offer(OP_TRANSPORT, RS_RESET, 4'($urandom), 7'($urandom), 7'($urandom));
		offer(OP_TRANSPORT, RS_RUNNING, 4'($urandom), 7'($urandom), 7'($urandom));
	endtask

	// receiver stall pattern, with one long hold-off while the sender keeps going
	initial begin
		int unsigned mode;
		int unsigned span;
		int unsigned cyc;
		bit          held_off;
		held_off = 0;
		cyc = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 80);
			repeat (span) begin
				if (!held_off && n_sent >= 45) begin
					held_off = 1;
					repeat (200) begin
						out_stall <= 1'b1;
						@(posedge clk);
					end
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= (cyc % 3 == 0);
				endcase
				cyc++;
				@(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("held_note_tracker_top regression: fail");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stopped: note events and unused code ignored, then notes, flushes, resets
		offer(OP_NOTE_ON, RS_RESET, 4'd15, 7'd127, 7'd127);
		offer(OP_NOTE_OFF, RS_RUNNING, 4'd15, 7'd127, 7'd0);
		offer(OP_UNUSED, RS_FIRST_TICK, 4'd1, 7'd1, 7'd1);
		offer(OP_TRANSPORT, RS_STOPPED, 4'd0, 7'd0, 7'd0);
		offer(OP_TRANSPORT, RS_FIRST_TICK, 4'd15, 7'd127, 7'd127);
		offer(OP_NOTE_ON, RS_STOPPED, 4'd0, 7'd0, 7'd0);
		offer(OP_NOTE_ON, RS_STOPPED, 4'd15, 7'd127, 7'd127);
		offer(OP_NOTE_ON, RS_STOPPED, 4'd5, 7'd60, 7'd64);
		offer(OP_NOTE_ON, RS_STOPPED, 4'd5, 7'd60, 7'd1);
		offer(OP_TRANSPORT, RS_RUNNING, 4'd0, 7'd0, 7'd0);
		offer(OP_NOTE_OFF, RS_STOPPED, 4'd5, 7'd60, 7'd0);
		offer(OP_NOTE_OFF, RS_STOPPED, 4'd9, 7'd9, 7'd9);
		offer(OP_UNUSED, RS_RUNNING, 4'd15, 7'd127, 7'd127);
		offer(OP_TRANSPORT, RS_STOPPED, 4'd0, 7'd0, 7'd0);
		offer(OP_NOTE_ON, RS_RUNNING, 4'd2, 7'd2, 7'd2);
		offer(OP_TRANSPORT, RS_RUNNING, 4'd0, 7'd0, 7'd0);
		offer(OP_NOTE_ON, RS_STOPPED, 4'd3, 7'd33, 7'd90);
		offer(OP_TRANSPORT, RS_RESET, 4'd0, 7'd0, 7'd0);
		offer(OP_TRANSPORT, RS_RUNNING, 4'd0, 7'd0, 7'd0);
		offer(OP_TRANSPORT, RS_RESET, 4'd0, 7'd0, 7'd0);
		offer(OP_TRANSPORT, RS_FIRST_TICK, 4'd0, 7'd0, 7'd0);
		offer(OP_NOTE_ON, RS_STOPPED, 4'd10, 7'd85, 7'd99);
		offer(OP_TRANSPORT, RS_STOPPED, 4'd0, 7'd0, 7'd0);
		offer(OP_TRANSPORT, RS_RESET, 4'd0, 7'd0, 7'd0);
		offer(OP_TRANSPORT, RS_RUNNING, 4'd0, 7'd0, 7'd0);
		settle();

		write_restart_velocity(7'd127);
		refresh_pool();
		random_note_events(25);
		settle();
		random_note_events(25);
		settle();

		write_restart_velocity(7'd0);
		fill_table();
		refresh_pool();
		random_note_events(30);
		settle();

		write_restart_velocity(7'($urandom_range(1, 126)));
		refresh_pool();
		random_note_events(35);
		settle();

		if (fail_count == 0)
			$display("held_note_tracker_top regression: pass");
		else
			$display("held_note_tracker_top regression: fail");
		$finish;
	end

endmodule
